/* rtl/core/cpg_pkg.sv */
// ----------------------------------------------------------------------------
// cpg_pkg: shared types and constants of the CPG gait generator
// Fixed gains, phase lags, replay frames, sine table builder and sequencer
// types used by the core, the shared multiplier and the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cpg_pkg;

    localparam int unsigned JOINT_COUNT   = 3;
    localparam int unsigned REPLAY_LENGTH = 50;
    localparam int unsigned JIDX_W        = 2;
    localparam int unsigned FRAME_W       = 6;
    localparam int unsigned ANGLE_W       = 16;
    localparam int unsigned AMP_W         = 13;
    localparam int unsigned OFS_W         = 16;
    localparam int unsigned FREQ_W        = 12;
    localparam int unsigned STEP_W        = 16;
    localparam int unsigned CFG_IDX_W     = 3;

    // Shared multiplier operand and result widths
    localparam int unsigned A_W   = 40;
    localparam int unsigned B_W   = 21;
    localparam int unsigned P_W   = A_W + B_W;
    localparam int unsigned RES_W = P_W + 1;

    localparam logic [STEP_W-1:0] DEFAULT_STEP = 16'd1311;
    localparam logic [FREQ_W-1:0] RESET_FREQ   = 12'd256;

    // Q16.16 gains
    localparam logic signed [B_W-1:0] GAIN_AMP = 21'sd765460;
    localparam logic signed [B_W-1:0] GAIN_OFS = 21'sd943718;
    localparam logic signed [B_W-1:0] GAIN_PH  = 21'sd382730;

    // Phase lags, Q0.32 turns
    localparam logic [31:0] LAG_A = 32'd477128562;
    localparam logic [31:0] LAG_B = 32'd954257125;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1073741824;

    typedef enum logic [3:0] {
        ST_IDLE, ST_AN, ST_ON, ST_PH, ST_AR, ST_OR, ST_C1, ST_C2, ST_NR, ST_OUT, ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        SUB_ISSUE, SUB_ROUND, SUB_WB
    } t_sub;

    typedef enum logic [1:0] {
        SH_8, SH_15, SH_16, SH_24
    } t_shift;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_AMP0, REG_AMP1, REG_AMP2, REG_OFS0, REG_OFS1, REG_OFS2, REG_FREQ, REG_STEP
    } t_reg_idx;

    typedef struct packed {
        logic [JOINT_COUNT-1:0][AMP_W-1:0] amp;
        logic [JOINT_COUNT-1:0][OFS_W-1:0] ofs;
        logic [FREQ_W-1:0]                 freq;
        logic [STEP_W-1:0]                 step;
    } t_cfg;

    typedef struct packed {
        logic start;
        logic take;
    } t_core_ctl;

    typedef struct packed {
        logic idle;
        logic done;
    } t_core_sts;

    // Recorded joint frames, Q3.12 radians
    localparam logic signed [ANGLE_W-1:0] REPLAY_ROM [REPLAY_LENGTH][JOINT_COUNT] = '{
        '{-160,-249,-143}, '{-107,-206,-306}, '{-128,-241,-368}, '{-440,-148,-342},
        '{-826,-175,-219}, '{-1428,-5,-116}, '{-2004,-181,139}, '{-2594,-277,238},
        '{-2936,-772,443}, '{-3327,-1152,466}, '{-3612,-1687,480}, '{-3957,-2079,178},
        '{-4060,-2396,-381}, '{-4132,-2616,-1124}, '{-3960,-2885,-1883},
        '{-3688,-3188,-2488}, '{-3237,-3469,-3082}, '{-2638,-3585,-3645},
        '{-2028,-3528,-4164}, '{-1508,-3178,-4582}, '{-1137,-2610,-4943},
        '{-626,-2059,-5074}, '{-57,-1623,-5064}, '{525,-1401,-4746},
        '{1238,-1184,-4298}, '{1806,-967,-3771}, '{2361,-449,-3116},
        '{2593,-26,-2521}, '{2678,463,-1871}, '{2506,837,-1454}, '{2121,1310,-655},
        '{1594,1704,143}, '{1088,1805,1226}, '{601,1877,1868}, '{176,1812,2351},
        '{-279,1651,2646}, '{-609,1267,2919}, '{-704,686,2999}, '{-611,100,2827},
        '{-420,-224,2131}, '{-89,-467,1478}, '{174,-537,838}, '{448,-589,289},
        '{514,-495,-241}, '{603,-451,-599}, '{524,-428,-637}, '{374,-280,-590},
        '{163,-132,-609}, '{121,-117,-557}, '{202,-313,-467}
    };

    // Saturate to signed 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // Coupling lag between joint i and joint j
    function automatic logic [31:0] lag_turns(input logic [JIDX_W-1:0] i,
                                              input logic [JIDX_W-1:0] j);
        logic [31:0] v;
        v = 32'd0;
        case ({i, j})
            4'b0001: v = 32'd0 - LAG_A;
            4'b0010: v = 32'd0 - (LAG_A + LAG_B);
            4'b0100: v = LAG_A;
            4'b0110: v = 32'd0 - LAG_B;
            4'b1000: v = LAG_A + LAG_B;
            4'b1001: v = LAG_B;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    // Quarter-wave sine entry, Q1.15, from a fixed integer Taylor series
    function automatic logic [15:0] sine_entry(input int unsigned k, input int unsigned bits);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        x  = (64'(k) * HALF_PI_Q30) >> (bits - 2);
        x2 = (x * x) >> 30;
        t  = ONE_Q30 - x2 / 110;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 72;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 42;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 20;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 6;
        s  = (x * t) >> 30;
        s  = (s + 64'd16384) >> 15;
        if (s > 64'd32767) begin
            s = 64'd32767;
        end
        return s[15:0];
    endfunction

endpackage

`default_nettype wire

/* rtl/core/cpg_mul_unit.sv */
// ----------------------------------------------------------------------------
// cpg_mul_unit: shared signed multiplier with rounding shift
// Registers the product, then rounds half up by the selected shift and
// registers the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cpg_mul_unit (
    input  logic                                i_clk,
    input  logic signed [cpg_pkg::A_W-1:0]      i_a,
    input  logic signed [cpg_pkg::B_W-1:0]      i_b,
    input  cpg_pkg::t_shift                     i_shift,
    output logic signed [cpg_pkg::RES_W-1:0]    o_res
);
    import cpg_pkg::*;

    logic signed [P_W-1:0]   r_prod;
    t_shift                  r_shift;
    logic signed [RES_W-1:0] r_res;
    logic signed [RES_W-1:0] w_biased;
    logic signed [RES_W-1:0] w_round;

    // Capture the product
    always_ff @(posedge i_clk) begin
        r_prod  <= i_a * i_b;
        r_shift <= i_shift;
    end

    // Add half an LSB, then shift arithmetically
    always_comb begin
        w_biased = {r_prod[P_W-1], r_prod};
        w_round  = '0;
        case (r_shift)
            SH_8: begin
                w_biased = {r_prod[P_W-1], r_prod} + RES_W'(128);
                w_round  = w_biased >>> 8;
            end
            SH_15: begin
                w_biased = {r_prod[P_W-1], r_prod} + RES_W'(16384);
                w_round  = w_biased >>> 15;
            end
            SH_16: begin
                w_biased = {r_prod[P_W-1], r_prod} + RES_W'(32768);
                w_round  = w_biased >>> 16;
            end
            default: begin
                w_biased = {r_prod[P_W-1], r_prod} + RES_W'(8388608);
                w_round  = w_biased >>> 24;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_res <= w_round;
    end

    assign o_res = r_res;

endmodule

`default_nettype wire

/* rtl/core/cpg_sine_rom.sv */
// ----------------------------------------------------------------------------
// cpg_sine_rom: phase to sine lookup
// Quarter-wave constant table built at elaboration, unfolded by quadrant.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cpg_sine_rom #(
    parameter int unsigned SINE_TABLE_BITS = 10
) (
    input  logic [31:0]                         i_phase,
    output logic signed [cpg_pkg::ANGLE_W-1:0]  o_sine
);
    import cpg_pkg::*;

    localparam int unsigned QSIZE = 1 << (SINE_TABLE_BITS - 2);

    logic [15:0]                  w_tab [QSIZE+1];
    logic [SINE_TABLE_BITS-1:0]   w_idx;
    logic [1:0]                   w_quad;
    logic [SINE_TABLE_BITS-2:0]   w_k;
    logic [15:0]                  w_mag;

    // Build the quarter-wave table
    for (genvar g = 0; g <= QSIZE; g++) begin : g_tab
        assign w_tab[g] = sine_entry(g, SINE_TABLE_BITS);
    end

    // Fold the phase into the first quadrant
    always_comb begin
        w_idx  = i_phase[31 -: SINE_TABLE_BITS];
        w_quad = w_idx[SINE_TABLE_BITS-1 -: 2];
        w_k    = {1'b0, w_idx[SINE_TABLE_BITS-3:0]};
        if (w_quad[0]) begin
            w_k = (SINE_TABLE_BITS-1)'(QSIZE) - w_k;
        end
        w_mag  = w_tab[w_k];
        o_sine = w_quad[1] ? -$signed(w_mag) : $signed(w_mag);
    end

endmodule

`default_nettype wire

/* rtl/core/cpg_core.sv */
// ----------------------------------------------------------------------------
// cpg_core: oscillator state and tick sequencer
// Steps the Euler update of all joints through the shared multiplier, one
// operation at a time, and forms the three joint angles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cpg_core #(
    parameter int unsigned SINE_TABLE_BITS = 10
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  cpg_pkg::t_cfg                       i_cfg,
    input  cpg_pkg::t_core_ctl                  i_ctl,
    output cpg_pkg::t_core_sts                  o_sts,
    output logic signed [cpg_pkg::ANGLE_W-1:0]  o_angle [cpg_pkg::JOINT_COUNT]
);
    import cpg_pkg::*;

    localparam logic [JIDX_W-1:0] LAST = JIDX_W'(JOINT_COUNT - 1);

    t_state              r_state, n_state;
    t_sub                r_sub, n_sub;
    logic [JIDX_W-1:0]   r_i, n_i;
    logic                r_k, n_k;

    logic signed [31:0]  r_amp_now  [JOINT_COUNT];
    logic signed [31:0]  r_amp_rate [JOINT_COUNT];
    logic signed [31:0]  r_ofs_now  [JOINT_COUNT];
    logic signed [31:0]  r_ofs_rate [JOINT_COUNT];
    logic [31:0]         r_phase    [JOINT_COUNT];
    logic signed [31:0]  r_ph_rate  [JOINT_COUNT];
    logic signed [A_W-1:0]     r_inner;
    logic signed [A_W-1:0]     r_acc;
    logic signed [ANGLE_W-1:0] r_angle [JOINT_COUNT];

    logic [JIDX_W-1:0]         w_j;
    logic [STEP_W-1:0]         w_dt;
    logic signed [B_W-1:0]     w_dtb;
    logic signed [A_W-1:0]     w_fq;
    logic signed [A_W-1:0]     w_ta;
    logic signed [A_W-1:0]     w_to;
    logic [31:0]               w_du;
    logic signed [ANGLE_W-1:0] w_sine;
    logic signed [A_W-1:0]     w_a;
    logic signed [B_W-1:0]     w_b;
    t_shift                    w_shift;
    logic signed [RES_W-1:0]   w_res;
    logic signed [31:0]        w_base;
    logic signed [63:0]        w_sum64;
    logic signed [31:0]        w_sat;
    logic signed [A_W-1:0]     w_inner;
    logic signed [33:0]        w_osum;
    logic signed [34:0]        w_ornd;
    logic signed [ANGLE_W-1:0] w_angle;
    logic                      w_last;

    cpg_mul_unit u_mul (
        .i_clk   (i_clk),
        .i_a     (w_a),
        .i_b     (w_b),
        .i_shift (w_shift),
        .o_res   (w_res)
    );

    cpg_sine_rom #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_sine (
        .i_phase (r_phase[r_i]),
        .o_sine  (w_sine)
    );

    // Select operands for the current operation
    always_comb begin
        if (!r_k) begin
            w_j = (r_i == '0) ? JIDX_W'(1) : JIDX_W'(0);
        end else begin
            w_j = (r_i == LAST) ? JIDX_W'(1) : LAST;
        end
        w_dt  = (i_cfg.step == '0) ? DEFAULT_STEP : i_cfg.step;
        w_dtb = $signed({5'b0, w_dt});
        w_fq  = $signed({12'b0, i_cfg.freq, 16'b0});
        w_ta  = $signed({15'b0, i_cfg.amp[r_i], 12'b0});
        w_to  = $signed({{12{i_cfg.ofs[r_i][OFS_W-1]}}, i_cfg.ofs[r_i], 12'b0});
        w_du  = r_phase[w_j] - r_phase[r_i] - lag_turns(r_i, w_j);
        w_a     = '0;
        w_b     = '0;
        w_shift = SH_16;
        case (r_state)
            ST_AN: begin
                w_a = A_W'(r_amp_rate[r_i]);
                w_b = w_dtb;
            end
            ST_ON: begin
                w_a = A_W'(r_ofs_rate[r_i]);
                w_b = w_dtb;
            end
            ST_PH: begin
                w_a     = A_W'(r_ph_rate[r_i]);
                w_b     = w_dtb;
                w_shift = SH_8;
            end
            ST_AR: begin
                w_a = w_ta - A_W'(r_amp_now[r_i]);
                w_b = GAIN_AMP;
            end
            ST_OR: begin
                w_a = w_to - A_W'(r_ofs_now[r_i]);
                w_b = GAIN_OFS;
            end
            ST_C1: begin
                w_a     = A_W'($signed(w_du));
                w_b     = GAIN_PH;
                w_shift = SH_24;
            end
            ST_C2: begin
                w_a = r_inner;
                w_b = GAIN_PH;
            end
            ST_NR: begin
                w_a = r_acc;
                w_b = w_dtb;
            end
            ST_OUT: begin
                w_a     = A_W'(r_amp_now[r_i]);
                w_b     = B_W'(w_sine);
                w_shift = SH_15;
            end
            default: begin
                w_a = '0;
            end
        endcase
    end

    // Form write-back values from the rounded product
    always_comb begin
        case (r_state)
            ST_AN:   w_base = r_amp_now[r_i];
            ST_ON:   w_base = r_ofs_now[r_i];
            ST_NR:   w_base = r_ph_rate[r_i];
            default: w_base = '0;
        endcase
        w_sum64 = 64'(w_base) + 64'(w_res);
        w_sat   = sat32(w_sum64);
        w_inner = w_res[A_W-1:0] - ((A_W'(r_ph_rate[r_i]) - w_fq) <<< 1);
        w_osum  = 34'(r_ofs_now[r_i]) + w_res[33:0];
        w_ornd  = (35'(w_osum) + 35'sd2048) >>> 12;
        if (w_ornd > 35'sd32767) begin
            w_angle = 16'sh7FFF;
        end else if (w_ornd < -35'sd32768) begin
            w_angle = 16'sh8000;
        end else begin
            w_angle = w_ornd[ANGLE_W-1:0];
        end
    end

    // Advance the sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_sub   <= SUB_ISSUE;
            r_i     <= '0;
            r_k     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sub   <= n_sub;
            r_i     <= n_i;
            r_k     <= n_k;
        end
    end

    always_comb begin
        w_last  = (r_i == LAST);
        n_state = r_state;
        n_sub   = r_sub;
        n_i     = r_i;
        n_k     = r_k;
        unique case (r_state)
            ST_IDLE: begin
                if (i_ctl.start) begin
                    n_state = ST_AN;
                    n_sub   = SUB_ISSUE;
                    n_i     = '0;
                    n_k     = 1'b0;
                end
            end
            ST_DONE: begin
                if (i_ctl.take) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                unique case (r_sub)
                    SUB_ISSUE: n_sub = SUB_ROUND;
                    SUB_ROUND: n_sub = SUB_WB;
                    default: begin
                        n_sub = SUB_ISSUE;
                        case (r_state)
                            ST_AN: n_state = ST_ON;
                            ST_ON: n_state = ST_PH;
                            ST_PH: begin
                                n_state = w_last ? ST_AR : ST_AN;
                                n_i     = w_last ? '0 : r_i + 1'b1;
                            end
                            ST_AR: n_state = ST_OR;
                            ST_OR: begin
                                n_state = w_last ? ST_C1 : ST_AR;
                                n_i     = w_last ? '0 : r_i + 1'b1;
                                n_k     = 1'b0;
                            end
                            ST_C1: n_state = ST_C2;
                            ST_C2: begin
                                if (!r_k) begin
                                    n_state = ST_C1;
                                    n_k     = 1'b1;
                                end else begin
                                    n_state = ST_NR;
                                end
                            end
                            ST_NR: begin
                                n_state = w_last ? ST_OUT : ST_C1;
                                n_i     = w_last ? '0 : r_i + 1'b1;
                                n_k     = 1'b0;
                            end
                            ST_OUT: begin
                                n_state = w_last ? ST_DONE : ST_OUT;
                                n_i     = w_last ? '0 : r_i + 1'b1;
                            end
                            default: n_state = ST_IDLE;
                        endcase
                    end
                endcase
            end
        endcase
    end

    // Write back oscillator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int n = 0; n < JOINT_COUNT; n++) begin
                r_amp_now[n]  <= '0;
                r_amp_rate[n] <= '0;
                r_ofs_now[n]  <= '0;
                r_ofs_rate[n] <= '0;
                r_phase[n]    <= '0;
                r_ph_rate[n]  <= '0;
            end
        end else if (r_sub == SUB_WB) begin
            case (r_state)
                ST_AN:  r_amp_now[r_i]  <= w_sat;
                ST_ON:  r_ofs_now[r_i]  <= w_sat;
                ST_PH:  r_phase[r_i]    <= r_phase[r_i] + w_res[31:0];
                ST_AR:  r_amp_rate[r_i] <= w_sat;
                ST_OR:  r_ofs_rate[r_i] <= w_sat;
                ST_NR:  r_ph_rate[r_i]  <= w_sat;
                default: begin
                end
            endcase
        end
    end

    // Hold coupling partials and angles
    always_ff @(posedge i_clk) begin
        if (r_sub == SUB_WB) begin
            case (r_state)
                ST_C1:  r_inner <= w_inner;
                ST_C2:  r_acc   <= (r_k ? r_acc : '0) + w_res[A_W-1:0];
                ST_OUT: r_angle[r_i] <= w_angle;
                default: begin
                end
            endcase
        end
    end

    assign o_sts.idle = (r_state == ST_IDLE);
    assign o_sts.done = (r_state == ST_DONE);
    assign o_angle    = r_angle;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.start |-> r_state == ST_IDLE)
        else $error("tick started while sequencer busy");

    a_sub_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE && r_state != ST_DONE && r_sub == SUB_ISSUE)
        |=> r_sub == SUB_ROUND)
        else $error("multiplier sub-step skipped");

    a_rate_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_NR && r_sub == SUB_WB && r_i == LAST)
        |=> (r_state == ST_OUT && r_i == '0))
        else $error("output pass did not follow last rate update");

    a_done_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && i_ctl.take) |=> r_state == ST_IDLE)
        else $error("sequencer stuck after result taken");

    a_joint_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_i <= LAST)
        else $error("joint index out of range");

endmodule

`default_nettype wire

/* rtl/core/cpg_oscillator_gait_generator.sv */
// ----------------------------------------------------------------------------
// cpg_oscillator_gait_generator: three-joint coupled-oscillator gait source
// Configuration registers, replay player, result register and the
// oscillator core with its shared multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on i_valid/o_ready: opcode 0 is a tick, opcode 1 arms
//   the 50-frame replay (sign from i_replay_negative) and gives no result.
//   Each tick gives one result on o_valid/i_ready: three joint angles in
//   Q3.12 radians and o_from_replay.
//   An oscillator tick runs 33 multiply operations through one shared
//   multiplier; the next request is taken once the core is idle again
//   and the output register is free. Replay ticks and triggers are
//   served from the replay table without the core.
//   Configuration writes use i_cfg_valid/o_cfg_ready with a register index
//   and data; o_cfg_ready is always high. Write only while idle.
//   Reset (synchronous, active low) clears all oscillator state, stops any
//   replay and loads the default registers (1 Hz, 0.02 s step).
//   When the receiver stalls, the result waits in the output register;
//   a finished tick holds in the core until that register is free, and no
//   new request is taken until then.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cpg_oscillator_gait_generator #(
    parameter int unsigned SINE_TABLE_BITS = 10
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_opcode,
    input  logic                                i_replay_negative,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [cpg_pkg::ANGLE_W-1:0]  o_angle_joint0,
    output logic signed [cpg_pkg::ANGLE_W-1:0]  o_angle_joint1,
    output logic signed [cpg_pkg::ANGLE_W-1:0]  o_angle_joint2,
    output logic                                o_from_replay,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [cpg_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [15:0]                         i_cfg_data
);
    import cpg_pkg::*;

    t_cfg                      r_cfg;
    logic                      r_replay_on;
    logic [FRAME_W-1:0]        r_replay_frame;
    logic                      r_replay_mirror;
    logic                      r_ovalid;
    logic                      r_from_replay;
    logic signed [ANGLE_W-1:0] r_angle [JOINT_COUNT];

    t_core_ctl                 w_ctl;
    t_core_sts                 w_sts;
    logic signed [ANGLE_W-1:0] w_core_angle [JOINT_COUNT];
    logic                      w_accept;
    logic                      w_out_free;
    logic                      w_play;
    logic [FRAME_W-1:0]        w_f;
    logic [FRAME_W-1:0]        w_f_next;

    cpg_core #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_ctl   (w_ctl),
        .o_sts   (w_sts),
        .o_angle (w_core_angle)
    );

    // Request handshake and core control
    always_comb begin
        w_out_free = !r_ovalid || i_ready;
        o_ready    = w_sts.idle && w_out_free;
        w_accept   = i_valid && o_ready;
        w_play     = w_accept && !i_opcode && r_replay_on;
        w_ctl.start = w_accept && !i_opcode && !r_replay_on;
        w_ctl.take  = w_sts.done && w_out_free;
        w_f      = (r_replay_frame < FRAME_W'(REPLAY_LENGTH)) ? r_replay_frame : '0;
        w_f_next = w_f + 1'b1;
    end

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.amp  <= '0;
            r_cfg.ofs  <= '0;
            r_cfg.freq <= RESET_FREQ;
            r_cfg.step <= DEFAULT_STEP;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_AMP0: r_cfg.amp[0] <= i_cfg_data[AMP_W-1:0];
                REG_AMP1: r_cfg.amp[1] <= i_cfg_data[AMP_W-1:0];
                REG_AMP2: r_cfg.amp[2] <= i_cfg_data[AMP_W-1:0];
                REG_OFS0: r_cfg.ofs[0] <= i_cfg_data;
                REG_OFS1: r_cfg.ofs[1] <= i_cfg_data;
                REG_OFS2: r_cfg.ofs[2] <= i_cfg_data;
                REG_FREQ: r_cfg.freq   <= i_cfg_data[FREQ_W-1:0];
                REG_STEP: r_cfg.step   <= i_cfg_data;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // Arm, advance and drop the replay
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_replay_on     <= 1'b0;
            r_replay_frame  <= '0;
            r_replay_mirror <= 1'b0;
        end else if (w_accept && i_opcode) begin
            r_replay_on     <= 1'b1;
            r_replay_frame  <= '0;
            r_replay_mirror <= i_replay_negative;
        end else if (w_play) begin
            if (w_f_next >= FRAME_W'(REPLAY_LENGTH)) begin
                r_replay_frame <= '0;
                r_replay_on    <= 1'b0;
            end else begin
                r_replay_frame <= w_f_next;
            end
        end
    end

    // Load and hold the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_play || w_ctl.take) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_play) begin
            for (int n = 0; n < JOINT_COUNT; n++) begin
                r_angle[n] <= r_replay_mirror ? -REPLAY_ROM[w_f][n] : REPLAY_ROM[w_f][n];
            end
            r_from_replay <= 1'b1;
        end else if (w_ctl.take) begin
            r_angle       <= w_core_angle;
            r_from_replay <= 1'b0;
        end
    end

    assign o_valid        = r_ovalid;
    assign o_angle_joint0 = r_angle[0];
    assign o_angle_joint1 = r_angle[1];
    assign o_angle_joint2 = r_angle[2];
    assign o_from_replay  = r_from_replay;

endmodule

`default_nettype wire
